FILE: rtl/sysmm_pkg.sv
// Shared constants, types and configuration register indexes of the systolic
// int8 matrix-multiply block. No dependencies.
package sysmm_pkg;

  // Grid geometry and arithmetic widths.
  localparam int unsigned GRID_SIZE = 4;
  localparam int unsigned SUM_WIDTH = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PROD_W    = 2 * BYTE_W;
  localparam int unsigned ACC_OUT_W = 32;
  localparam int unsigned RES_IDX_W = 2;
  localparam int unsigned ROW_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

  // Flush steps beyond twice the grid size change nothing.
  localparam int unsigned FLUSH_MAX = 2 * GRID_SIZE;
  localparam int unsigned FLUSH_W   = $clog2(FLUSH_MAX + 1);

  // Configuration port.
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_LENGTH  = 1'd1;
  localparam logic [CFG_W-1:0] STREAM_LENGTH_RST = 16'd8;
  localparam logic [CFG_W-1:0] FLUSH_LENGTH_RST  = 16'd10;

  typedef logic signed [BYTE_W-1:0]    byte_t;
  typedef logic signed [SUM_WIDTH-1:0] sum_t;

  // Per-step control that the sequencer hands to the grid.
  typedef struct packed {
    logic step;
    logic clear;
  } grid_ctrl_t;

endpackage

FILE: rtl/sysmm_pe.sv
// One multiply-accumulate cell of the systolic grid.
// Depends on sysmm_pkg.
module sysmm_pe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sysmm_pkg::grid_ctrl_t ctrl_i,
  input  sysmm_pkg::byte_t    a_i,
  input  sysmm_pkg::byte_t    b_i,
  output sysmm_pkg::byte_t    a_o,
  output sysmm_pkg::byte_t    b_o,
  output sysmm_pkg::sum_t     sum_o
);
  import sysmm_pkg::*;

  byte_t a_q, b_q;
  sum_t  sum_q, sum_d;
  logic signed [PROD_W-1:0] prod;

  // Product of the two arriving bytes, added to the wrapping sum.
  assign prod  = a_i * b_i;
  assign sum_d = (ctrl_i.clear ? sum_t'(0) : sum_q) + sum_t'(prod);

  // The cell only moves on a grid step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      b_q   <= '0;
      sum_q <= '0;
    end else if (ctrl_i.step) begin
      a_q   <= a_i;
      b_q   <= b_i;
      sum_q <= sum_d;
    end
  end

  assign a_o   = a_q;
  assign b_o   = b_q;
  assign sum_o = sum_q;

endmodule

FILE: rtl/sysmm_grid.sv
// Square grid of multiply-accumulate cells, bytes moving right and down.
// Depends on sysmm_pkg and sysmm_pe.
module sysmm_grid (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sysmm_pkg::grid_ctrl_t ctrl_i,
  input  sysmm_pkg::byte_t      left_i [sysmm_pkg::GRID_SIZE],
  input  sysmm_pkg::byte_t      top_i  [sysmm_pkg::GRID_SIZE],
  output sysmm_pkg::sum_t       sums_o [sysmm_pkg::GRID_SIZE][sysmm_pkg::GRID_SIZE]
);
  import sysmm_pkg::*;

  byte_t a_in  [GRID_SIZE][GRID_SIZE];
  byte_t b_in  [GRID_SIZE][GRID_SIZE];
  byte_t a_fwd [GRID_SIZE][GRID_SIZE];
  byte_t b_fwd [GRID_SIZE][GRID_SIZE];

  for (genvar r = 0; r < GRID_SIZE; r++) begin : g_row
    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
      // Left operand: edge byte or the left neighbor's forwarded byte,
      // which reads as zero on the clearing step of a run.
      if (c == 0) begin : g_left_edge
        assign a_in[r][c] = left_i[r];
      end else begin : g_left_inner
        assign a_in[r][c] = ctrl_i.clear ? byte_t'(0) : a_fwd[r][c-1];
      end

      // Upper operand, same rule along the column.
      if (r == 0) begin : g_top_edge
        assign b_in[r][c] = top_i[c];
      end else begin : g_top_inner
        assign b_in[r][c] = ctrl_i.clear ? byte_t'(0) : b_fwd[r-1][c];
      end

      sysmm_pe u_pe (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl_i),
        .a_i    (a_in[r][c]),
        .b_i    (b_in[r][c]),
        .a_o    (a_fwd[r][c]),
        .b_o    (b_fwd[r][c]),
        .sum_o  (sums_o[r][c])
      );
    end
  end

endmodule

FILE: rtl/systolic_int8_matmul_4x4.sv
// Top level: input and configuration ports, run sequencer, flush steps and
// result drain. Depends on sysmm_pkg and sysmm_grid.
// Throughput: one input transfer per cycle within a run; the grid takes one step per item.
// After the last item of a run the grid runs min(flush_length, 8) zero steps, one per
// cycle, then the 16 sums leave row-major at one result per cycle while not stalled.
// Results enter the registered output stage from the drain state, after the flush steps.
// Input is stalled during flush and drain. Reset clears all sums and restores the
// register defaults (stream_length 8, flush_length 10).
module systolic_int8_matmul_4x4 (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sysmm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sysmm_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [7:0]                     a_row_0_i,
  input  logic signed [7:0]                     a_row_1_i,
  input  logic signed [7:0]                     a_row_2_i,
  input  logic signed [7:0]                     a_row_3_i,
  input  logic signed [7:0]                     b_col_0_i,
  input  logic signed [7:0]                     b_col_1_i,
  input  logic signed [7:0]                     b_col_2_i,
  input  logic signed [7:0]                     b_col_3_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sysmm_pkg::RES_IDX_W-1:0]       result_row_o,
  output logic [sysmm_pkg::RES_IDX_W-1:0]       result_col_o,
  output logic signed [sysmm_pkg::ACC_OUT_W-1:0] accumulator_value_o,
  output logic                                  last_result_o
);
  import sysmm_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StFlush,
    StDrain
  } state_e;

  localparam logic [ROW_W-1:0]   LAST_IDX  = ROW_W'(GRID_SIZE - 1);
  localparam logic [FLUSH_W-1:0] FLUSH_CAP = FLUSH_W'(FLUSH_MAX);

  state_e state_q;
  logic [CFG_W-1:0]   stream_len_q, flush_len_q;
  logic [CFG_W-1:0]   items_q;
  logic [CFG_W:0]     items_next;
  logic [FLUSH_W-1:0] flush_cnt_q, flush_steps;
  logic [ROW_W-1:0]   row_q, col_q;
  logic               in_xfer, run_end, out_load, drain_last;

  logic                        out_valid_q, out_last_q;
  logic [ROW_W-1:0]            out_row_q, out_col_q;
  logic signed [ACC_OUT_W-1:0] out_value_q;

  grid_ctrl_t grid_ctrl;
  byte_t      left_edge [GRID_SIZE];
  byte_t      top_edge  [GRID_SIZE];
  sum_t       sums      [GRID_SIZE][GRID_SIZE];

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_len_q <= STREAM_LENGTH_RST;
      flush_len_q  <= FLUSH_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STREAM_LENGTH: stream_len_q <= cfg_data_i;
        CFG_FLUSH_LENGTH:  flush_len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input handshake and end-of-run detection. A zero length acts as one.
  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign items_next = {1'b0, items_q} + 1'b1;
  assign run_end    = (items_next >= {1'b0, stream_len_q});
  assign flush_steps = (flush_len_q > CFG_W'(FLUSH_MAX)) ? FLUSH_CAP
                                                          : flush_len_q[FLUSH_W-1:0];

  // Edge bytes come from the input transfer; flush steps feed zeros.
  always_comb begin
    left_edge[0] = a_row_0_i;
    left_edge[1] = a_row_1_i;
    left_edge[2] = a_row_2_i;
    left_edge[3] = a_row_3_i;
    top_edge[0]  = b_col_0_i;
    top_edge[1]  = b_col_1_i;
    top_edge[2]  = b_col_2_i;
    top_edge[3]  = b_col_3_i;
    if (state_q != StIdle) begin
      for (int i = 0; i < GRID_SIZE; i++) begin
        left_edge[i] = '0;
        top_edge[i]  = '0;
      end
    end
  end

  // Grid steps on every input transfer and every flush cycle.
  always_comb begin
    grid_ctrl.step  = in_xfer || (state_q == StFlush);
    grid_ctrl.clear = in_xfer && (items_q == '0);
  end

  sysmm_grid u_grid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (grid_ctrl),
    .left_i (left_edge),
    .top_i  (top_edge),
    .sums_o (sums)
  );

  // Output register loads when empty or when its result is taken.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign drain_last = (row_q == LAST_IDX) && (col_q == LAST_IDX);

  // Run sequencer with the registered result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      items_q     <= '0;
      flush_cnt_q <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
    end else begin
      // A free output register holds a result only while draining.
      if (out_load) begin
        out_valid_q <= (state_q == StDrain);
      end
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            if (run_end) begin
              items_q     <= '0;
              flush_cnt_q <= flush_steps;
              row_q       <= '0;
              col_q       <= '0;
              state_q     <= (flush_steps == '0) ? StDrain : StFlush;
            end else begin
              items_q <= items_next[CFG_W-1:0];
            end
          end
        end
        StFlush: begin
          flush_cnt_q <= flush_cnt_q - 1'b1;
          if (flush_cnt_q == FLUSH_W'(1)) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (out_load) begin
            out_row_q   <= row_q;
            out_col_q   <= col_q;
            out_value_q <= ACC_OUT_W'(sums[row_q][col_q]);
            out_last_q  <= drain_last;
            if (col_q == LAST_IDX) begin
              col_q <= '0;
              row_q <= (row_q == LAST_IDX) ? '0 : row_q + 1'b1;
            end else begin
              col_q <= col_q + 1'b1;
            end
            if (drain_last) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_row_o        = RES_IDX_W'(out_row_q);
  assign result_col_o        = RES_IDX_W'(out_col_q);
  assign accumulator_value_o = out_value_q;
  assign last_result_o       = out_last_q;

  // The grid only moves while taking items or flushing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grid_ctrl.step |-> (state_q == StIdle || state_q == StFlush))
    else $error("grid stepped outside a run or flush");

  // The last result of a run is always the bottom-right cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_row_q == LAST_IDX && out_col_q == LAST_IDX))
    else $error("last flag on a cell other than the final one");

  // A flush never runs with an exhausted step count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> (flush_cnt_q != '0 && flush_cnt_q <= FLUSH_CAP))
    else $error("flush step count out of range");

  // Leaving the drain, the next run starts from a cleared item count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain && out_load && drain_last) |=> (state_q == StIdle && items_q == '0))
    else $error("drain did not return to idle with a fresh run");

  // While the grid flushes or drains, the item count is already reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (items_q == '0))
    else $error("item count not cleared at end of run");

endmodule
